>>> rtl/assert_macros.svh
// Assertion helpers for the checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/tmcp_pkg.sv
package tmcp_pkg;

   // Fixed field widths of the request and response words.
   localparam int NODE_W      = 4;
   localparam int COST_IN_W   = 10;
   localparam int STAGE_OUT_W = 5;
   localparam int PATH_COST_W = 16;

   localparam logic [PATH_COST_W-1:0] PATH_COST_MAX = '1;

   // Control of one step of the add-compare-select unit.
   typedef struct packed {
      logic step;   // a cost word is being evaluated this cycle
      logic first;  // the word belongs to the first stage
      logic take;   // the candidate competes (indexes in range)
      logic close;  // the word ends its node, running state is cleared
   } acs_ctl_type;

   // Status of the running minimum after the current step.
   typedef struct packed {
      logic empty;  // no candidate has competed yet
      logic tie;    // an equal later candidate was seen
   } acs_flag_type;

endpackage

>>> rtl/tmcp_acs.sv
module tmcp_acs #(
   parameter int NODE_IDX_W = 4,
   parameter int COST_WIDTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  tmcp_pkg::acs_ctl_type              ctl,
   input  logic [COST_WIDTH-1:0]              prev_cost,
   input  logic [tmcp_pkg::COST_IN_W-1:0]     node_cost,
   input  logic [tmcp_pkg::COST_IN_W-1:0]     trans_cost,
   input  logic [NODE_IDX_W-1:0]              prev_node,
   output logic [COST_WIDTH-1:0]              best_cost,
   output logic [NODE_IDX_W-1:0]              best_prev,
   output tmcp_pkg::acs_flag_type             best_flag
);

   localparam int SUM_W = COST_WIDTH + 12;
   localparam logic [SUM_W-1:0] SAT_LIMIT = {{12{1'b0}}, {COST_WIDTH{1'b1}}};

   logic [COST_WIDTH-1:0] run_cost_ff, run_cost_in;
   logic [NODE_IDX_W-1:0] run_prev_ff, run_prev_in;
   logic                  run_tie_ff, run_tie_in;
   logic                  run_empty_ff, run_empty_in;

   logic [SUM_W-1:0]      sum;
   logic [COST_WIDTH-1:0] cand;
   logic [NODE_IDX_W-1:0] cand_prev;

   // Candidate: predecessor cost plus transition and node cost, saturated; on the first stage the node cost alone.
   always_comb begin
      if (ctl.first) begin
         sum = SUM_W'(node_cost);
      end else begin
         sum = SUM_W'(prev_cost) + SUM_W'(trans_cost) + SUM_W'(node_cost);
      end
      cand      = (sum > SAT_LIMIT) ? SAT_LIMIT[COST_WIDTH-1:0] : sum[COST_WIDTH-1:0];
      cand_prev = ctl.first ? '0 : prev_node;
   end

   // Compare-select against the running minimum; first strict minimum wins.
   always_comb begin
      best_cost       = run_cost_ff;
      best_prev       = run_prev_ff;
      best_flag.tie   = run_tie_ff;
      best_flag.empty = run_empty_ff;
      if (ctl.step && ctl.take) begin
         if (run_empty_ff || (cand < run_cost_ff)) begin
            best_cost       = cand;
            best_prev       = cand_prev;
            best_flag.tie   = 1'b0;
            best_flag.empty = 1'b0;
         end else if ((cand == run_cost_ff) && !ctl.first) begin
            best_flag.tie = 1'b1;
         end
      end
   end

   // The running state is cleared when a node closes.
   always_comb begin
      run_cost_in  = run_cost_ff;
      run_prev_in  = run_prev_ff;
      run_tie_in   = run_tie_ff;
      run_empty_in = run_empty_ff;
      if (ctl.step) begin
         if (ctl.close) begin
            run_cost_in  = '0;
            run_prev_in  = '0;
            run_tie_in   = 1'b0;
            run_empty_in = 1'b1;
         end else begin
            run_cost_in  = best_cost;
            run_prev_in  = best_prev;
            run_tie_in   = best_flag.tie;
            run_empty_in = best_flag.empty;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_cost_ff  <= '0;
         run_prev_ff  <= '0;
         run_tie_ff   <= 1'b0;
         run_empty_ff <= 1'b1;
      end else begin
         run_cost_ff  <= run_cost_in;
         run_prev_ff  <= run_prev_in;
         run_tie_ff   <= run_tie_in;
         run_empty_ff <= run_empty_in;
      end
   end

endmodule

>>> rtl/trellis_min_cost_path.sv
// Min-sum trellis path search with trace back.
// Request channel (req_*): valid/ready. A word with req_mode = 0 is one cost
// word for a (node, predecessor) pair of the current stage; a word with
// req_mode = 1 asks for the best path ending at req_end_node of the last
// committed stage.
// Response channel (rsp_*): valid/ready. A trace back gives one word per
// committed stage, last stage first, with rsp_last set on the stage-0 word.
// Cost words give no response.
// A cost word is handled as an accumulated-cost memory read, then one
// add-compare-select step in the shared unit; req_ready is low meanwhile.
// A trace back first reads the end cost, then for each stage does a survivor
// memory read and then gives the response word, plus any stall of the
// receiver; req_ready stays low until the stage-0 word is taken.
// While rsp_ready is low the response word holds and the block waits.
// Reset empties the trellis and clears the running minimum; the memories
// are not cleared and need no pass after reset.
module trellis_min_cost_path #(
   parameter int MAX_NODES  = 16,
   parameter int MAX_STAGES = 32,
   parameter int COST_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_mode,
   input  logic                                 req_stage_first,
   input  logic [tmcp_pkg::NODE_W-1:0]          req_node_index,
   input  logic [tmcp_pkg::COST_IN_W-1:0]       req_node_cost,
   input  logic [tmcp_pkg::NODE_W-1:0]          req_prev_index,
   input  logic [tmcp_pkg::COST_IN_W-1:0]       req_trans_cost,
   input  logic                                 req_last_prev,
   input  logic                                 req_last_node,
   input  logic [tmcp_pkg::NODE_W-1:0]          req_end_node,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [tmcp_pkg::STAGE_OUT_W-1:0]     rsp_stage_index,
   output logic [tmcp_pkg::NODE_W-1:0]          rsp_path_node,
   output logic [tmcp_pkg::PATH_COST_W-1:0]     rsp_path_cost,
   output logic                                 rsp_tie_seen,
   output logic                                 rsp_last
);

   localparam int NODE_IDX_W  = $clog2(MAX_NODES);
   localparam int STG_IDX_W   = $clog2(MAX_STAGES);
   localparam int STG_CNT_W   = $clog2(MAX_STAGES + 1);
   localparam int BANK_DEPTH  = 2 * MAX_NODES;
   localparam int BANK_AW     = $clog2(BANK_DEPTH);
   localparam int STORE_DEPTH = MAX_STAGES * MAX_NODES;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);
   localparam int EXT_W       = COST_WIDTH + tmcp_pkg::PATH_COST_W;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CALC   = 3'd1;
   localparam logic [2:0] ST_RBCOST = 3'd2;
   localparam logic [2:0] ST_RBREAD = 3'd3;
   localparam logic [2:0] ST_RBOUT  = 3'd4;

   function automatic logic [BANK_AW-1:0] bank_addr(input logic bank,
                                                    input logic [NODE_IDX_W-1:0] node);
      logic [BANK_AW-1:0] base;
      base = bank ? BANK_AW'(MAX_NODES) : '0;
      return base + BANK_AW'(node);
   endfunction

   function automatic logic [STORE_AW-1:0] store_addr(input logic [STG_IDX_W-1:0] stage,
                                                      input logic [NODE_IDX_W-1:0] node);
      logic [STORE_AW-1:0] base;
      base = STORE_AW'(stage) * STORE_AW'(MAX_NODES);
      return base + STORE_AW'(node);
   endfunction

   // Control state.
   logic [2:0]           state_ff, state_in;
   logic                 bank_sel_ff, bank_sel_in;
   logic [STG_CNT_W-1:0] stage_cnt_ff, stage_cnt_in;

   // Latched cost word.
   logic                          it_first_ff, it_take_ff, it_close_ff, it_commit_ff;
   logic                          it_node_ok_ff;
   logic [NODE_IDX_W-1:0]         it_node_ff, it_prev_ff;
   logic [tmcp_pkg::COST_IN_W-1:0] it_ncost_ff, it_tcost_ff;
   logic [STG_IDX_W-1:0]          it_stage_ff;

   // Trace back position and response register.
   logic [STG_IDX_W-1:0]             rb_stage_ff, rb_stage_in;
   logic [NODE_IDX_W-1:0]            rb_node_ff, rb_node_in;
   logic [tmcp_pkg::PATH_COST_W-1:0] rb_cost_ff, rb_cost_in;
   logic [tmcp_pkg::STAGE_OUT_W-1:0] rsp_stage_ff;
   logic [tmcp_pkg::NODE_W-1:0]      rsp_node_ff;
   logic [tmcp_pkg::PATH_COST_W-1:0] rsp_cost_ff;
   logic                             rsp_tie_ff, rsp_last_ff;

   // Memories: accumulated cost banks, survivor with tie flag on top.
   logic [COST_WIDTH-1:0] acc_mem [BANK_DEPTH];
   logic [COST_WIDTH-1:0] acc_rd_ff;
   logic [NODE_IDX_W:0]   store_mem [STORE_DEPTH];
   logic [NODE_IDX_W:0]   store_rd_ff;

   logic                    req_fire;
   logic                    req_node_ok, req_prev_ok, req_end_ok, req_in_range;
   logic [STG_CNT_W-1:0]    req_cur;
   logic [NODE_IDX_W-1:0]   req_node_n, req_prev_n, req_end_n;
   logic [BANK_AW-1:0]      acc_raddr, acc_waddr;
   logic [STG_IDX_W-1:0]    rd_stage;
   logic [STORE_AW-1:0]     store_raddr, store_waddr;
   logic                    calc_write;
   logic [EXT_W-1:0]        acc_ext;

   tmcp_pkg::acs_ctl_type   acs_ctl;
   logic [COST_WIDTH-1:0]   best_cost;
   logic [NODE_IDX_W-1:0]   best_prev;
   tmcp_pkg::acs_flag_type  best_flag;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = (state_ff == ST_RBOUT);

   // Request decode.
   always_comb begin
      req_node_ok  = 32'(req_node_index) < MAX_NODES;
      req_prev_ok  = 32'(req_prev_index) < MAX_NODES;
      req_end_ok   = 32'(req_end_node) < MAX_NODES;
      req_node_n   = NODE_IDX_W'(req_node_index);
      req_prev_n   = NODE_IDX_W'(req_prev_index);
      req_end_n    = NODE_IDX_W'(req_end_node);
      req_cur      = req_stage_first ? '0 : stage_cnt_ff;
      req_in_range = 32'(req_cur) < MAX_STAGES;
   end

   // Memory addresses.
   always_comb begin
      acc_raddr   = bank_addr(bank_sel_ff, req_mode ? req_end_n : req_prev_n);
      acc_waddr   = bank_addr(~bank_sel_ff, it_node_ff);
      rd_stage    = (state_ff == ST_RBOUT) ? rb_stage_ff - 1'b1 : rb_stage_ff;
      store_raddr = store_addr(rd_stage, rb_node_ff);
      store_waddr = store_addr(it_stage_ff, it_node_ff);
      calc_write  = (state_ff == ST_CALC) && it_close_ff && it_node_ok_ff;
      acc_ext     = EXT_W'(acc_rd_ff);
   end

   // Shared add-compare-select unit.
   always_comb begin
      acs_ctl.step  = (state_ff == ST_CALC);
      acs_ctl.first = it_first_ff;
      acs_ctl.take  = it_take_ff;
      acs_ctl.close = it_close_ff;
   end

   tmcp_acs #(
      .NODE_IDX_W (NODE_IDX_W),
      .COST_WIDTH (COST_WIDTH)
   ) u_acs (
      .clock      (clock),
      .reset      (reset),
      .ctl        (acs_ctl),
      .prev_cost  (acc_rd_ff),
      .node_cost  (it_ncost_ff),
      .trans_cost (it_tcost_ff),
      .prev_node  (it_prev_ff),
      .best_cost  (best_cost),
      .best_prev  (best_prev),
      .best_flag  (best_flag)
   );

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      bank_sel_in  = bank_sel_ff;
      stage_cnt_in = stage_cnt_ff;
      rb_stage_in  = rb_stage_ff;
      rb_node_in   = rb_node_ff;
      rb_cost_in   = rb_cost_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (!req_mode) begin
                  if (req_in_range) begin
                     state_in = ST_CALC;
                  end
               end else if ((stage_cnt_ff != '0) && req_end_ok) begin
                  rb_stage_in = STG_IDX_W'(stage_cnt_ff - 1'b1);
                  rb_node_in  = req_end_n;
                  state_in    = ST_RBCOST;
               end
            end
         end
         ST_CALC: begin
            if (it_commit_ff) begin
               bank_sel_in  = ~bank_sel_ff;
               stage_cnt_in = STG_CNT_W'(it_stage_ff) + STG_CNT_W'(1);
            end
            state_in = ST_IDLE;
         end
         ST_RBCOST: begin
            if (acc_ext > EXT_W'(tmcp_pkg::PATH_COST_MAX)) begin
               rb_cost_in = tmcp_pkg::PATH_COST_MAX;
            end else begin
               rb_cost_in = acc_ext[tmcp_pkg::PATH_COST_W-1:0];
            end
            state_in = ST_RBREAD;
         end
         ST_RBREAD: begin
            rb_node_in = store_rd_ff[NODE_IDX_W-1:0];
            state_in   = ST_RBOUT;
         end
         ST_RBOUT: begin
            if (rsp_ready) begin
               if (rsp_last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  rb_stage_in = rb_stage_ff - 1'b1;
                  state_in    = ST_RBREAD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bank_sel_ff  <= 1'b0;
         stage_cnt_ff <= '0;
      end else begin
         state_ff     <= state_in;
         bank_sel_ff  <= bank_sel_in;
         stage_cnt_ff <= stage_cnt_in;
      end
   end

   // Cost word capture.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         it_first_ff   <= req_stage_first;
         it_take_ff    <= req_node_ok && (req_stage_first || req_prev_ok);
         it_close_ff   <= req_last_prev || req_last_node;
         it_commit_ff  <= req_last_node;
         it_node_ok_ff <= req_node_ok;
         it_node_ff    <= req_node_n;
         it_prev_ff    <= req_prev_n;
         it_ncost_ff   <= req_node_cost;
         it_tcost_ff   <= req_trans_cost;
         it_stage_ff   <= STG_IDX_W'(req_cur);
      end
   end

   // Trace back position and response word.
   always_ff @(posedge clock) begin
      rb_stage_ff <= rb_stage_in;
      rb_node_ff  <= rb_node_in;
      rb_cost_ff  <= rb_cost_in;
      if (state_ff == ST_RBREAD) begin
         rsp_stage_ff <= tmcp_pkg::STAGE_OUT_W'(rb_stage_ff);
         rsp_node_ff  <= tmcp_pkg::NODE_W'(rb_node_ff);
         rsp_cost_ff  <= rb_cost_ff;
         rsp_tie_ff   <= store_rd_ff[NODE_IDX_W];
         rsp_last_ff  <= (rb_stage_ff == '0);
      end
   end

   // Accumulated cost memory; an empty node stores the saturated cost.
   always_ff @(posedge clock) begin
      if (calc_write) begin
         acc_mem[acc_waddr] <= best_flag.empty ? {COST_WIDTH{1'b1}} : best_cost;
      end
      acc_rd_ff <= acc_mem[acc_raddr];
   end

   // Survivor and tie memory.
   always_ff @(posedge clock) begin
      if (calc_write) begin
         store_mem[store_waddr] <= best_flag.empty ? '0 : {best_flag.tie, best_prev};
      end
      store_rd_ff <= store_mem[store_raddr];
   end

   assign rsp_stage_index = rsp_stage_ff;
   assign rsp_path_node   = rsp_node_ff;
   assign rsp_path_cost   = rsp_cost_ff;
   assign rsp_tie_seen    = rsp_tie_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

>>> rtl/tmcp_checker.sv
`include "assert_macros.svh"

module tmcp_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic [tmcp_pkg::STAGE_OUT_W-1:0]     rsp_stage_index,
   input logic [tmcp_pkg::NODE_W-1:0]          rsp_path_node,
   input logic [tmcp_pkg::PATH_COST_W-1:0]     rsp_path_cost,
   input logic                                 rsp_last
);

   // A stalled response word holds.
   `ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_path_node) && $stable(rsp_path_cost))

   // No request is taken while a response word is pending.
   `ASSERT_IMP(a_busy_on_rsp, clock, reset, rsp_valid, !req_ready)

   // After a word that is not the last, the trace back continues.
   `ASSERT_NXT(a_run_continues, clock, reset, rsp_valid && rsp_ready && !rsp_last, !req_ready)

   // The word that ends a run is the one for stage zero.
   `ASSERT_IMP(a_last_stage_zero, clock, reset, rsp_valid && rsp_last, rsp_stage_index == '0)

endmodule

bind trellis_min_cost_path tmcp_checker u_tmcp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_stage_index (rsp_stage_index),
   .rsp_path_node   (rsp_path_node),
   .rsp_path_cost   (rsp_path_cost),
   .rsp_last        (rsp_last)
);
